>>> rtl/core/ksm_pkg.sv
// Shared types, constants and codes of the k-best minimum sampler.
// No dependencies; used by the interfaces, the top level and the testbench.
package ksm_pkg;

  // Default sizing
  localparam int K_MAX_DEF      = 8;
  localparam int VALUE_BITS_DEF = 40;

  // Configuration register layout
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam int KEEP_BITS     = 4;
  localparam int TOL_BITS      = 16;
  localparam int LIMIT_BITS    = 16;
  localparam int COUNT_BITS    = 16;

  localparam logic [CFG_IDX_BITS-1:0] CFG_KEEP_COUNT   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TOLERANCE    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SAMPLE_LIMIT = 2'd2;

  localparam logic [KEEP_BITS-1:0]  KEEP_RESET  = 4'd3;
  localparam logic [TOL_BITS-1:0]   TOL_RESET   = 16'd655;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 16'd500;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX   = 16'hFFFF;

  // Status codes
  localparam logic [1:0] STATUS_PENDING   = 2'd0;
  localparam logic [1:0] STATUS_CONVERGED = 2'd1;
  localparam logic [1:0] STATUS_NEVER     = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_SHIFT,
    ST_PLACE,
    ST_MIN_RD,
    ST_MIN_CAP,
    ST_KTH_CAP,
    ST_RESULT
  } state_t;

endpackage

>>> rtl/core/ksm_in_if.sv
// Input channel of the k-best minimum sampler: one timing sample per item.
// Depends on ksm_pkg for the default value width.
interface ksm_in_if #(
  parameter int VALUE_BITS = ksm_pkg::VALUE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] sample_value;
  logic                  begin_run;

  modport source (output valid, output sample_value, output begin_run, input ready);
  modport sink   (input valid, input sample_value, input begin_run, output ready);
endinterface

>>> rtl/core/ksm_out_if.sv
// Result channel of the k-best minimum sampler: one report per sample.
// Depends on ksm_pkg for the default value width and the count width.
interface ksm_out_if #(
  parameter int VALUE_BITS = ksm_pkg::VALUE_BITS_DEF
);
  logic                            valid;
  logic                            ready;
  logic [1:0]                      status;
  logic [VALUE_BITS-1:0]           current_min;
  logic [VALUE_BITS-1:0]           kth_value;
  logic [ksm_pkg::COUNT_BITS-1:0]  sample_count;

  modport source (output valid, output status, output current_min, output kth_value,
                  output sample_count, input ready);
  modport sink   (input valid, input status, input current_min, input kth_value,
                  input sample_count, output ready);
endinterface

>>> rtl/core/ksm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ksm_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] store [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
    rdata <= store[raddr];
  end

endmodule

>>> rtl/core/k_best_min_sampler_top.sv
// Top level of the k-best minimum sampler.
// Depends on ksm_pkg, ksm_in_if, ksm_out_if and ksm_ram.
//
// Keeps the k smallest samples of the current run, ascending, in a small RAM
// and reports min, k-th smallest, count and convergence status per item. One
// item at a time: a sample that is not kept goes from the compare straight to
// the min and k-th reads; a kept one first walks its insertion, one RAM read
// and one write per position moved. The result sits in an output register so
// the next item is taken while it waits. The RAM is not cleared; an entry
// beyond the held count may be read but its value is never reported.
module k_best_min_sampler_top #(
  parameter int K_MAX      = ksm_pkg::K_MAX_DEF,
  parameter int VALUE_BITS = ksm_pkg::VALUE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  ksm_in_if.sink                           in,
  ksm_out_if.source                        out,
  input  logic                             cfg_we,
  input  logic [ksm_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [ksm_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  localparam int AW = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int KW = $clog2(K_MAX + 1);
  localparam int HW = VALUE_BITS - 16;

  // Configuration registers
  logic [ksm_pkg::KEEP_BITS-1:0]  keep_count;
  logic [ksm_pkg::TOL_BITS-1:0]   tolerance;
  logic [ksm_pkg::LIMIT_BITS-1:0] sample_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count   <= ksm_pkg::KEEP_RESET;
      tolerance    <= ksm_pkg::TOL_RESET;
      sample_limit <= ksm_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ksm_pkg::CFG_KEEP_COUNT:   keep_count   <= cfg_data[ksm_pkg::KEEP_BITS-1:0];
        ksm_pkg::CFG_TOLERANCE:    tolerance    <= cfg_data[ksm_pkg::TOL_BITS-1:0];
        ksm_pkg::CFG_SAMPLE_LIMIT: sample_limit <= cfg_data[ksm_pkg::LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Effective k: zero means one, clamp at K_MAX
  logic [KW-1:0] k_eff;
  always_comb begin
    if (keep_count == '0) begin
      k_eff = KW'(1);
    end else if (32'(keep_count) > K_MAX) begin
      k_eff = KW'(K_MAX);
    end else begin
      k_eff = KW'(keep_count);
    end
  end

  // Sequencer and working registers
  ksm_pkg::state_t state, state_next;
  logic [VALUE_BITS-1:0]          v_r;
  logic [AW-1:0]                  p_r, p_next;
  logic [KW-1:0]                  held, held_next;
  logic [KW-1:0]                  k_r;
  logic [ksm_pkg::COUNT_BITS-1:0] taken, taken_next;
  logic [VALUE_BITS-1:0]          mn_r, kth_r;
  logic [VALUE_BITS-1:0]          prod_hi;
  logic [15:0]                    prod_lo;

  // RAM ports
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [VALUE_BITS-1:0] ram_wdata, ram_rdata;

  ksm_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(K_MAX)
  ) u_list (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Output register
  logic                           out_valid;
  logic [1:0]                     out_status;
  logic [VALUE_BITS-1:0]          out_min, out_kth;
  logic [ksm_pkg::COUNT_BITS-1:0] out_count;
  logic                           out_free;
  logic                           out_load;

  assign out_free         = !out_valid || out.ready;
  assign out.valid        = out_valid;
  assign out.status       = out_status;
  assign out.current_min  = out_min;
  assign out.kth_value    = out_kth;
  assign out.sample_count = out_count;

  assign in.ready = (state == ksm_pkg::ST_IDLE);

  // Base values at accept: a new run clears held and count
  logic [KW-1:0]                  held_base;
  logic [ksm_pkg::COUNT_BITS-1:0] taken_base;
  assign held_base  = in.begin_run ? '0 : held;
  assign taken_base = in.begin_run ? '0 : taken;

  // Convergence check from registered products
  logic                  held_full;
  logic [VALUE_BITS:0]   slack;
  logic [VALUE_BITS-1:0] spread;
  logic                  converged;
  logic [1:0]            status_calc;
  assign held_full = (held >= k_r);
  assign slack     = {1'b0, prod_hi} + (VALUE_BITS + 1)'(prod_lo);
  assign spread    = kth_r - mn_r;
  assign converged = held_full && ({1'b0, spread} <= slack);

  always_comb begin
    if (converged) begin
      status_calc = ksm_pkg::STATUS_CONVERGED;
    end else if (taken >= sample_limit) begin
      status_calc = ksm_pkg::STATUS_NEVER;
    end else begin
      status_calc = ksm_pkg::STATUS_PENDING;
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ksm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, RAM control and bookkeeping
  always_comb begin
    state_next = state;
    p_next     = p_r;
    held_next  = held;
    taken_next = taken;
    ram_we     = 1'b0;
    ram_waddr  = p_r;
    ram_wdata  = v_r;
    ram_raddr  = '0;
    out_load   = 1'b0;
    unique case (state)
      ksm_pkg::ST_IDLE: begin
        if (in.valid) begin
          held_next  = held_base;
          taken_next = (taken_base == ksm_pkg::COUNT_MAX) ? taken_base : taken_base + 1'b1;
          if (held_base < k_eff) begin
            // still filling: insert at the end of the list
            held_next = held_base + 1'b1;
            p_next    = AW'(held_base);
            if (held_base == '0) begin
              state_next = ksm_pkg::ST_PLACE;
            end else begin
              ram_raddr  = AW'(held_base - 1'b1);
              state_next = ksm_pkg::ST_SHIFT;
            end
          end else begin
            ram_raddr  = AW'(k_eff - 1'b1);
            state_next = ksm_pkg::ST_CMP;
          end
        end
      end
      ksm_pkg::ST_CMP: begin
        // rdata is the entry at k-1
        if (v_r < ram_rdata) begin
          p_next = AW'(k_r - 1'b1);
          if (k_r == KW'(1)) begin
            state_next = ksm_pkg::ST_PLACE;
          end else begin
            ram_raddr  = AW'(k_r - 2'd2);
            state_next = ksm_pkg::ST_SHIFT;
          end
        end else begin
          state_next = ksm_pkg::ST_MIN_RD;
        end
      end
      ksm_pkg::ST_SHIFT: begin
        // rdata is the entry at p-1; move it up while it is larger
        if (ram_rdata > v_r) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          p_next    = p_r - 1'b1;
          if (p_r == AW'(1)) begin
            state_next = ksm_pkg::ST_PLACE;
          end else begin
            ram_raddr = p_r - 2'd2;
          end
        end else begin
          ram_we     = 1'b1;
          state_next = ksm_pkg::ST_MIN_RD;
        end
      end
      ksm_pkg::ST_PLACE: begin
        ram_we     = 1'b1;
        state_next = ksm_pkg::ST_MIN_RD;
      end
      ksm_pkg::ST_MIN_RD: begin
        ram_raddr  = '0;
        state_next = ksm_pkg::ST_MIN_CAP;
      end
      ksm_pkg::ST_MIN_CAP: begin
        ram_raddr  = AW'(k_r - 1'b1);
        state_next = ksm_pkg::ST_KTH_CAP;
      end
      ksm_pkg::ST_KTH_CAP: begin
        state_next = ksm_pkg::ST_RESULT;
      end
      ksm_pkg::ST_RESULT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ksm_pkg::ST_IDLE;
        end
      end
      default: state_next = ksm_pkg::ST_IDLE;
    endcase
  end

  // Control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      held  <= '0;
      taken <= '0;
    end else begin
      held  <= held_next;
      taken <= taken_next;
    end
  end

  // Datapath registers
  logic [HW-1:0]         mn_hi;
  logic [VALUE_BITS-1:0] hi_prod;
  logic [31:0]           lo_prod;
  assign mn_hi   = mn_r[VALUE_BITS-1:16];
  assign hi_prod = mn_hi * tolerance;
  assign lo_prod = mn_r[15:0] * tolerance;

  always_ff @(posedge clk) begin
    p_r <= p_next;
    if (in.valid && in.ready) begin
      v_r <= in.sample_value;
      k_r <= k_eff;
    end
    if (state == ksm_pkg::ST_MIN_CAP) begin
      mn_r <= ram_rdata;
    end
    if (state == ksm_pkg::ST_KTH_CAP) begin
      kth_r   <= ram_rdata;
      prod_hi <= hi_prod;
      prod_lo <= lo_prod[31:16];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= status_calc;
      out_min    <= mn_r;
      out_kth    <= held_full ? kth_r : '0;
      out_count  <= taken;
    end
  end

endmodule

>>> tb/tb.sv
// Testbench of k_best_min_sampler_top: a directed table, random runs of samples
// and a back-to-back pass, checked against the table or an in-bench list model.
// Depends on ksm_pkg, ksm_in_if, ksm_out_if and the sampler RTL.
module tb;
  import ksm_pkg::*;

  localparam int VW           = VALUE_BITS_DEF;
  localparam int KM           = K_MAX_DEF;
  localparam int STALL_LIMIT  = 4000;
  localparam int LONG_HOLD    = 250;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 52;
  localparam int STEADY_ITEMS = 20;
  localparam int MAX_PRINTS   = 40;

  typedef logic [VW-1:0] value_t;

  typedef struct packed {
    logic [1:0]            status;
    value_t                min_v;
    value_t                kth_v;
    logic [COUNT_BITS-1:0] count;
  } report_t;

  typedef enum bit {STEP_SAMPLE, STEP_WRITE} step_e;

  // sample rows: fresh flag, value, typed check; write rows: data in value, idx
  typedef struct packed {
    step_e                   kind;
    bit                      fresh;
    value_t                  value;
    logic [CFG_IDX_BITS-1:0] idx;
    bit                      typed;
    report_t                 want;
  } step_t;

  localparam value_t VMAX = 40'hFF_FFFF_FFFF;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  ksm_in_if  #(.VALUE_BITS(VW)) smp_if ();
  ksm_out_if #(.VALUE_BITS(VW)) rep_if ();

  k_best_min_sampler_top #(.K_MAX(KM), .VALUE_BITS(VW)) uut (
    .clk       (clk),
    .rst       (rst),
    .in        (smp_if),
    .out       (rep_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Directed table; defaults after reset are k=3, tol=655, limit=500
  step_t script [29] = '{
    '{STEP_SAMPLE, 1'b1, 40'd1000,  CFG_KEEP_COUNT, 1'b1,
      '{STATUS_PENDING, 40'd1000, 40'd0, 16'd1}},
    '{STEP_SAMPLE, 1'b0, 40'd0,     CFG_KEEP_COUNT, 1'b1,
      '{STATUS_PENDING, 40'd0, 40'd0, 16'd2}},
    '{STEP_SAMPLE, 1'b0, VMAX,      CFG_KEEP_COUNT, 1'b1,
      '{STATUS_PENDING, 40'd0, VMAX, 16'd3}},
    '{STEP_SAMPLE, 1'b0, 40'd500,   CFG_KEEP_COUNT, 1'b1,
      '{STATUS_PENDING, 40'd0, 40'd1000, 16'd4}},
    '{STEP_SAMPLE, 1'b0, 40'd2000,  CFG_KEEP_COUNT, 1'b1,
      '{STATUS_PENDING, 40'd0, 40'd1000, 16'd5}},
    // margin exactly equal to kth - min converges, one above does not
    '{STEP_SAMPLE, 1'b1, 40'd65536, CFG_KEEP_COUNT, 1'b1,
      '{STATUS_PENDING, 40'd65536, 40'd0, 16'd1}},
    '{STEP_SAMPLE, 1'b0, 40'd66191, CFG_KEEP_COUNT, 1'b1,
      '{STATUS_PENDING, 40'd65536, 40'd0, 16'd2}},
    '{STEP_SAMPLE, 1'b0, 40'd65636, CFG_KEEP_COUNT, 1'b1,
      '{STATUS_CONVERGED, 40'd65536, 40'd66191, 16'd3}},
    '{STEP_SAMPLE, 1'b1, 40'd65536, CFG_KEEP_COUNT, 1'b1,
      '{STATUS_PENDING, 40'd65536, 40'd0, 16'd1}},
    '{STEP_SAMPLE, 1'b0, 40'd66192, CFG_KEEP_COUNT, 1'b1,
      '{STATUS_PENDING, 40'd65536, 40'd0, 16'd2}},
    '{STEP_SAMPLE, 1'b0, 40'd66192, CFG_KEEP_COUNT, 1'b1,
      '{STATUS_PENDING, 40'd65536, 40'd66192, 16'd3}},
    // single kept entry, then keep count zero acts as one
    '{STEP_WRITE,  1'b0, 40'd1,     CFG_KEEP_COUNT, 1'b0, '0},
    '{STEP_SAMPLE, 1'b1, VMAX,      CFG_KEEP_COUNT, 1'b1,
      '{STATUS_CONVERGED, VMAX, VMAX, 16'd1}},
    '{STEP_SAMPLE, 1'b0, 40'd7,     CFG_KEEP_COUNT, 1'b1,
      '{STATUS_CONVERGED, 40'd7, 40'd7, 16'd2}},
    '{STEP_WRITE,  1'b0, 40'd0,     CFG_KEEP_COUNT, 1'b0, '0},
    '{STEP_SAMPLE, 1'b0, 40'd3,     CFG_KEEP_COUNT, 1'b1,
      '{STATUS_CONVERGED, 40'd3, 40'd3, 16'd3}},
    // keep count above the maximum, mid-run, with limit reached
    '{STEP_WRITE,  1'b0, 40'd15,    CFG_KEEP_COUNT, 1'b0, '0},
    '{STEP_WRITE,  1'b0, 40'd0,     CFG_TOLERANCE, 1'b0, '0},
    '{STEP_WRITE,  1'b0, 40'd1,     CFG_SAMPLE_LIMIT, 1'b0, '0},
    '{STEP_SAMPLE, 1'b0, 40'd9,     CFG_KEEP_COUNT, 1'b1,
      '{STATUS_NEVER, 40'd3, 40'd0, 16'd4}},
    // limit zero; upper data bits dropped on the keep count
    '{STEP_WRITE,  1'b0, 40'd0,     CFG_SAMPLE_LIMIT, 1'b0, '0},
    '{STEP_WRITE,  1'b0, 40'hFFF2,  CFG_KEEP_COUNT, 1'b0, '0},
    '{STEP_SAMPLE, 1'b1, 40'd5,     CFG_KEEP_COUNT, 1'b1,
      '{STATUS_NEVER, 40'd5, 40'd0, 16'd1}},
    '{STEP_SAMPLE, 1'b0, 40'd5,     CFG_KEEP_COUNT, 1'b1,
      '{STATUS_CONVERGED, 40'd5, 40'd5, 16'd2}},
    // widest tolerance and limit
    '{STEP_WRITE,  1'b0, 40'hFFFF,  CFG_TOLERANCE, 1'b0, '0},
    '{STEP_WRITE,  1'b0, 40'hFFFF,  CFG_SAMPLE_LIMIT, 1'b0, '0},
    '{STEP_SAMPLE, 1'b0, 40'd10,    CFG_KEEP_COUNT, 1'b1,
      '{STATUS_CONVERGED, 40'd5, 40'd5, 16'd3}},
    '{STEP_SAMPLE, 1'b1, 40'd100,   CFG_KEEP_COUNT, 1'b1,
      '{STATUS_PENDING, 40'd100, 40'd0, 16'd1}},
    '{STEP_SAMPLE, 1'b0, 40'd199,   CFG_KEEP_COUNT, 1'b1,
      '{STATUS_CONVERGED, 40'd100, 40'd199, 16'd2}}
  };

  // In-bench copy of the sampler state and registers
  value_t                kept_list [KM];
  int                    kept_held;
  logic [COUNT_BITS-1:0] taken_total;
  logic [KEEP_BITS-1:0]  keep_reg;
  logic [TOL_BITS-1:0]   tol_reg;
  logic [LIMIT_BITS-1:0] limit_reg;

  report_t pending_reports [$];
  report_t due;
  int      errors;
  int      reports_seen;
  int      idle_cycles;
  bit      long_hold_req;
  bit      rx_steady;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic value_t rand_value();
    return value_t'({$urandom, $urandom});
  endfunction

  // Updates the kept list for one sample and returns the report it causes
  function automatic report_t track_sample(input bit fresh, input value_t v);
    int          k;
    int          p;
    bit          placed;
    value_t      t;
    logic [63:0] margin;
    report_t     r;
    k = (keep_reg == 0) ? 1 : ((keep_reg > KM) ? KM : int'(keep_reg));
    p = 0;
    placed = 1'b0;
    if (fresh) begin
      taken_total = '0;
      kept_held = 0;
    end
    if (kept_held < k) begin
      p = kept_held;
      kept_list[p] = v;
      kept_held++;
      placed = 1'b1;
    end else if (v < kept_list[k-1]) begin
      p = k - 1;
      kept_list[p] = v;
      placed = 1'b1;
    end
    if (taken_total != COUNT_MAX) taken_total++;
    // sort the new entry down into place
    while (placed && p > 0 && kept_list[p-1] > kept_list[p]) begin
      t = kept_list[p-1];
      kept_list[p-1] = kept_list[p];
      kept_list[p] = t;
      p--;
    end
    r.min_v = kept_list[0];
    r.kth_v = '0;
    r.status = STATUS_PENDING;
    if (kept_held >= k) begin
      r.kth_v = kept_list[k-1];
      margin = (64'(r.min_v) * 64'(tol_reg)) >> 16;
      if (64'(r.kth_v - r.min_v) <= margin) r.status = STATUS_CONVERGED;
    end
    if (r.status == STATUS_PENDING && taken_total >= limit_reg) r.status = STATUS_NEVER;
    r.count = taken_total;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= MAX_PRINTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Offers one item, records its expected report, then idles a random gap unless steady
  task automatic offer_sample(input bit fresh, input value_t v, input bit steady,
                              input bit typed, input report_t want);
    report_t got;
    int      gap;
    int      pick;
    smp_if.valid        <= 1'b1;
    smp_if.begin_run    <= fresh;
    smp_if.sample_value <= v;
    do @(posedge clk); while (smp_if.ready !== 1'b1);
    got = track_sample(fresh, v);
    pending_reports.push_back(typed ? want : got);
    gap = 0;
    if (!steady) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) gap = 0;
      else if (pick < 88) gap = $urandom_range(1, 3);
      else if (pick < 98) gap = $urandom_range(4, 15);
      else gap = $urandom_range(30, 80);
    end
    if (gap > 0) begin
      smp_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering and waits for every outstanding report
  task automatic drain();
    smp_if.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_KEEP_COUNT:   keep_reg = data[KEEP_BITS-1:0];
      CFG_TOLERANCE:    tol_reg = data;
      CFG_SAMPLE_LIMIT: limit_reg = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Result side: random stalls, calm stretches and long hold-offs on request
  initial begin : rx_side
    int hold;
    int calm;
    int pick;
    hold = 0;
    calm = 0;
    rep_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        rep_if.ready <= 1'b0;
      end else begin
        if (hold == 0 && calm == 0 && !rx_steady) begin
          pick = $urandom_range(0, 99);
          if (pick < 20) hold = $urandom_range(1, 3);
          else if (pick < 23) hold = $urandom_range(10, 40);
          else if (pick < 28) calm = $urandom_range(20, 80);
        end
        if (long_hold_req) begin
          long_hold_req = 1'b0;
          hold = LONG_HOLD;
        end
        if (hold > 0) begin
          hold--;
          rep_if.ready <= 1'b0;
        end else begin
          if (calm > 0) calm--;
          rep_if.ready <= 1'b1;
        end
      end
    end
  end

  // Report checker
  always @(posedge clk) begin
    if (!rst && rep_if.valid === 1'b1 && rep_if.ready === 1'b1) begin
      reports_seen++;
      if (reports_seen == 60 || reports_seen == 300) long_hold_req = 1'b1;
      if (pending_reports.size() == 0) begin
        errors++;
        if (errors <= MAX_PRINTS)
          $display("%0t: report with none expected, status %0h min %0h kth %0h count %0h",
                   $time, rep_if.status, rep_if.current_min, rep_if.kth_value,
                   rep_if.sample_count);
      end else begin
        due = pending_reports.pop_front();
        check_field("status", 64'(due.status), 64'(rep_if.status));
        check_field("current_min", 64'(due.min_v), 64'(rep_if.current_min));
        check_field("kth_value", 64'(due.kth_v), 64'(rep_if.kth_value));
        check_field("sample_count", 64'(due.count), 64'(rep_if.sample_count));
      end
    end
  end

  // Watchdog: ends the run when neither side moves an item for too long
  always @(posedge clk) begin
    if (rst || (smp_if.valid === 1'b1 && smp_if.ready === 1'b1) ||
        (rep_if.valid === 1'b1 && rep_if.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == STALL_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin : stim
    int     i;
    int     phase;
    int     run_left;
    bit     fresh;
    value_t base;
    value_t spread;
    value_t v;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    smp_if.valid = 1'b0;
    smp_if.begin_run = 1'b0;
    smp_if.sample_value = '0;
    kept_held = 0;
    taken_total = '0;
    keep_reg = KEEP_RESET;
    tol_reg = TOL_RESET;
    limit_reg = LIMIT_RESET;
    errors = 0;
    reports_seen = 0;
    idle_cycles = 0;
    long_hold_req = 1'b0;
    rx_steady = 1'b0;
    run_left = 0;
    base = '0;
    spread = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    foreach (script[n]) begin
      if (script[n].kind == STEP_WRITE) begin
        drain();
        write_reg(script[n].idx, script[n].value[CFG_DATA_BITS-1:0]);
      end else begin
        offer_sample(script[n].fresh, script[n].value, 1'b0, script[n].typed, script[n].want);
      end
    end

    // Random runs over several register settings; runs may span a change
    for (phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase)
        0: write_reg(CFG_KEEP_COUNT, 16'd1);
        1: write_reg(CFG_KEEP_COUNT, 16'(KM));
        2: write_reg(CFG_KEEP_COUNT, 16'd0);
        3: write_reg(CFG_KEEP_COUNT, 16'd15);
        default: write_reg(CFG_KEEP_COUNT, 16'($urandom_range(0, 15)));
      endcase
      case (phase % 4)
        0: write_reg(CFG_TOLERANCE, 16'd0);
        1: write_reg(CFG_TOLERANCE, 16'hFFFF);
        2: write_reg(CFG_TOLERANCE, 16'($urandom_range(300, 3000)));
        default: write_reg(CFG_TOLERANCE, 16'($urandom_range(0, 65535)));
      endcase
      case (phase % 4)
        0: write_reg(CFG_SAMPLE_LIMIT, 16'($urandom_range(1, 40)));
        1: write_reg(CFG_SAMPLE_LIMIT, 16'hFFFF);
        2: write_reg(CFG_SAMPLE_LIMIT, 16'd1);
        default: write_reg(CFG_SAMPLE_LIMIT, 16'($urandom_range(0, 600)));
      endcase
      for (i = 0; i < PHASE_ITEMS; i++) begin
        fresh = 1'b0;
        if (run_left == 0) begin
          // new run: values clustered around a base of random magnitude
          run_left = $urandom_range(1, 40);
          fresh = 1'b1;
          base = rand_value() >> $urandom_range(0, VW - 1);
          spread = base >> $urandom_range(3, 12);
        end
        run_left--;
        if ($urandom_range(0, 9) < 7) v = base + (rand_value() % (spread + 1));
        else v = rand_value();
        offer_sample(fresh, v, 1'b0, 1'b0, '0);
      end
    end

    // Back-to-back run with a receiver that never holds off
    drain();
    write_reg(CFG_KEEP_COUNT, 16'(KM));
    write_reg(CFG_TOLERANCE, 16'd0);
    write_reg(CFG_SAMPLE_LIMIT, 16'hFFFF);
    rx_steady = 1'b1;
    for (i = 0; i < STEADY_ITEMS; i++)
      offer_sample(i == 0, rand_value(), 1'b1, 1'b0, '0);
    drain();
    rx_steady = 1'b0;

    repeat (2 * KM + 8) @(posedge clk);
    if (errors == 0 && pending_reports.size() == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule
